// ===== design/cubic_hermite_stereo_resampler_macros.svh =====
// assertion macros shared by the resampler modules
`ifndef CUBIC_HERMITE_STEREO_RESAMPLER_MACROS_SVH
`define CUBIC_HERMITE_STEREO_RESAMPLER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define CHSR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define CHSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/chsr_pkg.sv =====
// shared types, constants and helper functions of the cubic stereo resampler
package chsr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 18;
    localparam int DIG_W    = 8;
    localparam int COEF_W   = 20;
    localparam int A_W      = 17;
    localparam int B_W      = 20;

    localparam logic [STEP_W-1:0]          STEP_RESET = 18'd43691;
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX    = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN    = 16'sh8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_MUL_B,
        ST_MUL_A,
        ST_MUL_S,
        ST_ROUND,
        ST_FINISH
    } ctrl_state_t;

    // term added at the end of each horner pass
    typedef enum logic [1:0] {
        ADD_B,
        ADD_A,
        ADD_S
    } addend_sel_t;

    typedef struct packed {
        logic        capture;
        logic        slot_adv;
        logic        load;
        logic        mul_en;
        addend_sel_t addend;
        logic        emit;
        logic        finish;
    } dp_cmd_t;

    typedef struct packed {
        logic slots_none;
        logic pos_below_one;
        logic dig_last;
        logic out_busy;
    } dp_status_t;

    typedef struct packed {
        logic        load;
        logic        mul_en;
        logic        mul_first;
        logic        mul_last;
        addend_sel_t addend;
    } lane_ctl_t;

    // window index of one tap, clamped to the frames of the chunk
    function automatic logic [1:0] clamp_index(logic [1:0] slot, logic [1:0] tap,
                                               logic [1:0] lo);
        logic signed [3:0] v;
        v = $signed({2'b00, slot}) + $signed({2'b00, tap}) - 4'sd1;
        if (v < $signed({2'b00, lo})) begin
            return lo;
        end else if (v > 4'sd3) begin
            return 2'd3;
        end else begin
            return v[1:0];
        end
    endfunction

endpackage

// ===== design/chsr_lane.sv =====
// one channel: catmull-rom coefficients, digit-serial horner and round/saturate
module chsr_lane
    import chsr_pkg::*;
#(
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                       aclk,
    input  lane_ctl_t                  ctl,
    input  logic [DIG_W-1:0]           dig,
    input  logic signed [SAMPLE_W-1:0] tap0,
    input  logic signed [SAMPLE_W-1:0] tap1,
    input  logic signed [SAMPLE_W-1:0] tap2,
    input  logic signed [SAMPLE_W-1:0] tap3,
    output logic signed [SAMPLE_W-1:0] result
);

    localparam int F  = PHASE_FRAC_BITS;
    localparam int AW = 3 * F + 24;
    localparam int SH = 3 * F + 1;
    localparam logic signed [AW-1:0] LIM     = AW'(17'd65535) << (3 * F);
    localparam logic signed [AW-1:0] NEG_LIM = -LIM;

    logic signed [COEF_W-1:0]   e0, e1, e2, e3;
    logic signed [COEF_W-1:0]   a_calc, b_calc, c_calc;
    logic signed [A_W-1:0]      a_reg;
    logic signed [B_W-1:0]      b_reg;
    logic signed [SAMPLE_W-1:0] s1_reg;
    logic signed [AW-1:0]       x_reg, r_reg;
    logic signed [AW+DIG_W:0]   prod_full;
    logic signed [AW-1:0]       prod, part, addend;
    logic signed [SAMPLE_W:0]   q, rnd;
    logic                       frac_nz, sat_hi, sat_lo;

    // polynomial coefficients from the four taps
    always_comb begin
        e0 = {{(COEF_W-SAMPLE_W){tap0[SAMPLE_W-1]}}, tap0};
        e1 = {{(COEF_W-SAMPLE_W){tap1[SAMPLE_W-1]}}, tap1};
        e2 = {{(COEF_W-SAMPLE_W){tap2[SAMPLE_W-1]}}, tap2};
        e3 = {{(COEF_W-SAMPLE_W){tap3[SAMPLE_W-1]}}, tap3};
        a_calc = e2 - e0;
        b_calc = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
        c_calc = ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3 - e0;
    end

    // one fraction digit per cycle, most significant digit first
    always_comb begin
        prod_full = x_reg * $signed({1'b0, dig});
        prod      = prod_full[AW-1:0];
        part      = (ctl.mul_first ? '0 : (r_reg <<< DIG_W)) + prod;
    end

    // term scaled to the fraction weight of each pass
    always_comb begin
        case (ctl.addend)
            ADD_B:   addend = {{(AW-B_W){b_reg[B_W-1]}}, b_reg} << F;
            ADD_A:   addend = {{(AW-A_W){a_reg[A_W-1]}}, a_reg} << (2 * F);
            ADD_S:   addend = {{(AW-SAMPLE_W-1){s1_reg[SAMPLE_W-1]}}, s1_reg, 1'b1}
                              << (3 * F);
            default: addend = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            a_reg  <= a_calc[A_W-1:0];
            b_reg  <= b_calc[B_W-1:0];
            s1_reg <= tap1;
            x_reg  <= {{(AW-COEF_W){c_calc[COEF_W-1]}}, c_calc};
        end else if (ctl.mul_en) begin
            if (ctl.mul_last) begin
                x_reg <= part + addend;
            end else begin
                r_reg <= part;
            end
        end
    end

    // saturate, else truncate (2v+1)/2 toward zero
    always_comb begin
        sat_hi  = x_reg > LIM;
        sat_lo  = x_reg < NEG_LIM;
        q       = x_reg[SH+SAMPLE_W:SH];
        frac_nz = |x_reg[SH-1:0];
        rnd     = q + $signed({{SAMPLE_W{1'b0}}, x_reg[AW-1] & frac_nz});
        if (sat_hi) begin
            result = OUT_MAX;
        end else if (sat_lo) begin
            result = OUT_MIN;
        end else begin
            result = rnd[SAMPLE_W-1:0];
        end
    end

endmodule

// ===== design/chsr_datapath.sv =====
// frame history, output position, two channel lanes and the result register
`include "cubic_hermite_stereo_resampler_macros.svh"
module chsr_datapath
    import chsr_pkg::*;
#(
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic [2*SAMPLE_W-1:0] s_tdata,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2*SAMPLE_W-1:0] m_tdata,
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [STEP_W-1:0]   cfg_data
);

    localparam int F     = PHASE_FRAC_BITS;
    localparam int POS_W = ((F > STEP_W) ? F : STEP_W) + 1;
    localparam int NDIG  = (F + DIG_W - 1) / DIG_W;
    localparam int FP    = NDIG * DIG_W;
    localparam int DCW   = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int INT_W = POS_W - F + 2;
    localparam logic [POS_W-1:0] ONE_POS  = {{(POS_W-1){1'b0}}, 1'b1} << F;
    localparam logic [POS_W-1:0] MIN_STEP = ONE_POS >> 2;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        fs_reg, fs_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [1:0]        slot_reg, slot_next;
    logic [1:0]        slots_left_reg, slots_left_next;
    logic              end_reg, end_next;
    logic [DCW-1:0]    dig_cnt_reg, dig_cnt_next;
    logic              out_valid_reg, out_valid_next;

    logic signed [SAMPLE_W-1:0] h0_l_reg, h1_l_reg, h2_l_reg, new_l_reg;
    logic signed [SAMPLE_W-1:0] h0_r_reg, h1_r_reg, h2_r_reg, new_r_reg;
    logic signed [SAMPLE_W-1:0] out_l_reg, out_r_reg;
    logic                       out_last_reg;

    logic [1:0]       lo, idx0, idx1, idx2, idx3;
    logic [POS_W-1:0] step_eff, p_next, pos_drop;
    logic [FP-1:0]    fpad;
    logic [DCW-1:0]   dig_idx;
    logic [DIG_W-1:0] dig;
    logic             dig_last, last;
    logic [1:0]       first_slot, slot_count;
    lane_ctl_t        lane_ctl;
    logic signed [SAMPLE_W-1:0] tl0, tl1, tl2, tl3, tr0, tr1, tr2, tr3;
    logic signed [SAMPLE_W-1:0] res_l, res_r;

    function automatic logic signed [SAMPLE_W-1:0] pick(logic [1:0] sel,
        logic signed [SAMPLE_W-1:0] f0, logic signed [SAMPLE_W-1:0] f1,
        logic signed [SAMPLE_W-1:0] f2, logic signed [SAMPLE_W-1:0] f3);
        case (sel)
            2'd0:    return f0;
            2'd1:    return f1;
            2'd2:    return f2;
            default: return f3;
        endcase
    endfunction

    // window taps for the current slot
    always_comb begin
        lo   = 2'd3 - fs_reg;
        idx0 = clamp_index(slot_reg, 2'd0, lo);
        idx1 = clamp_index(slot_reg, 2'd1, lo);
        idx2 = clamp_index(slot_reg, 2'd2, lo);
        idx3 = clamp_index(slot_reg, 2'd3, lo);
        tl0 = pick(idx0, h0_l_reg, h1_l_reg, h2_l_reg, new_l_reg);
        tl1 = pick(idx1, h0_l_reg, h1_l_reg, h2_l_reg, new_l_reg);
        tl2 = pick(idx2, h0_l_reg, h1_l_reg, h2_l_reg, new_l_reg);
        tl3 = pick(idx3, h0_l_reg, h1_l_reg, h2_l_reg, new_l_reg);
        tr0 = pick(idx0, h0_r_reg, h1_r_reg, h2_r_reg, new_r_reg);
        tr1 = pick(idx1, h0_r_reg, h1_r_reg, h2_r_reg, new_r_reg);
        tr2 = pick(idx2, h0_r_reg, h1_r_reg, h2_r_reg, new_r_reg);
        tr3 = pick(idx3, h0_r_reg, h1_r_reg, h2_r_reg, new_r_reg);
    end

    // position arithmetic and fraction digit
    always_comb begin
        step_eff = ({{(POS_W-STEP_W){1'b0}}, step_reg} < MIN_STEP) ? MIN_STEP
                 : {{(POS_W-STEP_W){1'b0}}, step_reg};
        p_next   = pos_reg + step_eff;
        pos_drop = (pos_reg >= ONE_POS) ? pos_reg - ONE_POS : '0;
        // last result once the next position clears every remaining slot
        last     = INT_W'(p_next >> F) >= INT_W'(slots_left_reg);
        fpad     = FP'(pos_reg[F-1:0]);
        dig_idx  = DCW'(NDIG - 1) - dig_cnt_reg;
        dig      = fpad[dig_idx*DIG_W +: DIG_W];
        dig_last = dig_cnt_reg == DCW'(NDIG - 1);
    end

    // slots to visit for the arriving frame
    always_comb begin
        if (s_tlast) begin
            first_slot = (lo == 2'd0) ? 2'd1 : lo;
            slot_count = (fs_reg == 2'd3) ? 2'd3 : fs_reg + 2'd1;
        end else begin
            first_slot = 2'd1;
            slot_count = {1'b0, fs_reg[1]};
        end
    end

    // control register next values
    always_comb begin
        step_next       = step_reg;
        fs_next         = fs_reg;
        pos_next        = pos_reg;
        slot_next       = slot_reg;
        slots_left_next = slots_left_reg;
        end_next        = end_reg;
        dig_cnt_next    = dig_cnt_reg;
        out_valid_next  = out_valid_reg;
        if (cfg_valid) begin
            step_next = cfg_data;
        end
        if (cmd.capture) begin
            end_next        = s_tlast;
            slot_next       = first_slot;
            slots_left_next = slot_count;
            dig_cnt_next    = '0;
        end
        if (cmd.slot_adv) begin
            pos_next        = pos_drop;
            slot_next       = slot_reg + 2'd1;
            slots_left_next = slots_left_reg - 2'd1;
        end
        if (cmd.mul_en) begin
            dig_cnt_next = dig_last ? '0 : dig_cnt_reg + DCW'(1);
        end
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            pos_next       = p_next;
            out_valid_next = 1'b1;
        end
        if (cmd.finish) begin
            if (end_reg) begin
                fs_next  = 2'd0;
                pos_next = '0;
            end else begin
                fs_next = (fs_reg == 2'd3) ? 2'd3 : fs_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg       <= STEP_RESET;
            fs_reg         <= 2'd0;
            pos_reg        <= '0;
            slot_reg       <= 2'd0;
            slots_left_reg <= 2'd0;
            end_reg        <= 1'b0;
            dig_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            step_reg       <= step_next;
            fs_reg         <= fs_next;
            pos_reg        <= pos_next;
            slot_reg       <= slot_next;
            slots_left_reg <= slots_left_next;
            end_reg        <= end_next;
            dig_cnt_reg    <= dig_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // frame history and result payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            new_l_reg <= s_tdata[SAMPLE_W-1:0];
            new_r_reg <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
        end
        if (cmd.finish && !end_reg) begin
            h0_l_reg <= h1_l_reg;
            h1_l_reg <= h2_l_reg;
            h2_l_reg <= new_l_reg;
            h0_r_reg <= h1_r_reg;
            h1_r_reg <= h2_r_reg;
            h2_r_reg <= new_r_reg;
        end
        if (cmd.emit) begin
            out_l_reg    <= res_l;
            out_r_reg    <= res_r;
            out_last_reg <= last;
        end
    end

    assign lane_ctl = '{load: cmd.load, mul_en: cmd.mul_en, mul_first: dig_cnt_reg == '0,
                        mul_last: dig_last, addend: cmd.addend};

    chsr_lane #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_lane_l (
        .aclk   (aclk),
        .ctl    (lane_ctl),
        .dig    (dig),
        .tap0   (tl0),
        .tap1   (tl1),
        .tap2   (tl2),
        .tap3   (tl3),
        .result (res_l)
    );

    chsr_lane #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_lane_r (
        .aclk   (aclk),
        .ctl    (lane_ctl),
        .dig    (dig),
        .tap0   (tr0),
        .tap1   (tr1),
        .tap2   (tr2),
        .tap3   (tr3),
        .result (res_r)
    );

    // status back to the controller and port drive
    assign status.slots_none    = slots_left_reg == 2'd0;
    assign status.pos_below_one = pos_reg < ONE_POS;
    assign status.dig_last      = dig_last;
    assign status.out_busy      = out_valid_reg && !m_tready;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_r_reg, out_l_reg};
    assign m_tlast   = out_last_reg;
    assign cfg_ready = 1'b1;

    `CHSR_ASSERT_SAME(a_emit_reg_free, cmd.emit, !(out_valid_reg && !m_tready), "result register overwritten")
    `CHSR_ASSERT_SAME(a_emit_in_frame, cmd.emit, pos_reg < ONE_POS, "result taken past the current frame")
    `CHSR_ASSERT_SAME(a_load_has_slot, cmd.load, slots_left_reg != 2'd0, "load with no slot left")
    `CHSR_ASSERT_NEXT(a_chunk_clear, cmd.finish && end_reg, fs_reg == 2'd0 && pos_reg == '0, "chunk end left state behind")

endmodule

// ===== design/chsr_ctrl.sv =====
// sequencer for capture, slot walk, horner passes and result transfer
`include "cubic_hermite_stereo_resampler_macros.svh"
module chsr_ctrl
    import chsr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.slots_none) begin
                    state_next = ST_FINISH;
                end else if (status.pos_below_one) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:  state_next = ST_MUL_B;
            ST_MUL_B: begin
                if (status.dig_last) begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                if (status.dig_last) begin
                    state_next = ST_MUL_S;
                end
            end
            ST_MUL_S: begin
                if (status.dig_last) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (!status.out_busy) begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_CHECK: cmd.slot_adv = !status.slots_none && !status.pos_below_one;
            ST_LOAD:  cmd.load = 1'b1;
            ST_MUL_B: begin
                cmd.mul_en = 1'b1;
                cmd.addend = ADD_B;
            end
            ST_MUL_A: begin
                cmd.mul_en = 1'b1;
                cmd.addend = ADD_A;
            end
            ST_MUL_S: begin
                cmd.mul_en = 1'b1;
                cmd.addend = ADD_S;
            end
            ST_ROUND:  cmd.emit = !status.out_busy;
            ST_FINISH: cmd.finish = 1'b1;
            default: begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `CHSR_ASSERT_SAME(a_one_cmd, 1'b1, $onehot0({cmd.capture, cmd.slot_adv, cmd.load, cmd.mul_en, cmd.emit, cmd.finish}), "more than one datapath command")
    `CHSR_ASSERT_NEXT(a_capture_check, cmd.capture, state_reg == ST_CHECK, "transfer not followed by slot check")
    `CHSR_ASSERT_NEXT(a_emit_return, cmd.emit, state_reg == ST_CHECK && !s_tready, "result not followed by slot check")

endmodule

// ===== design/cubic_hermite_stereo_resampler.sv =====
// top level of the catmull-rom cubic stereo resampler
//
//  channel  ports       tdata / data bits             side bit
//  input    s_*         [15:0] left, [31:16] right    tlast: chunk end
//  output   m_*         [15:0] left, [31:16] right    tlast: last result of frame
//  config   cfg_*       [17:0] phase step, Q2.16      none
//
//  a frame with no result passes the check and finish states; each result adds a load,
//  three horner passes through the 8-bit digit-serial multiplier and a round state
//  the check state is repeated for each window slot the position steps over
//  aresetn is synchronous; there is no clearing pass
//  a result waits in the output register; a further result stalls until it is taken
//  the input is taken only between frames, also while a result waits
module cubic_hermite_stereo_resampler
    import chsr_pkg::*;
#(
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*SAMPLE_W-1:0] s_tdata,   // in_left [15:0], in_right [31:16]
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*SAMPLE_W-1:0] m_tdata,   // out_left [15:0], out_right [31:16]
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [STEP_W-1:0]     cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    chsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    chsr_datapath #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== tb/tb_cubic_hermite_stereo_resampler.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the cubic stereo resampler: directed frames, then random chunks
module tb_cubic_hermite_stereo_resampler;
    import chsr_pkg::*;

    localparam int FRAC          = 16;
    localparam int unsigned ONE_FRAME = 1 << FRAC;
    localparam int unsigned QUARTER   = ONE_FRAME >> 2;
    localparam int MAX_PER_FRAME = 12;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_ITEMS   = 39;
    localparam int N_PHASES      = 7;
    localparam int N_DIRECTED    = 23;
    localparam int PREDICT       = -1;
    localparam logic [STEP_W-1:0] STEP_MAX = 18'h3ffff;

    typedef struct {
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
    } frame_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
        logic                       last;
    } sample_out_t;

    // one directed frame; n_typed results of (el, er), or PREDICT
    typedef struct {
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
        logic                       ends;
        int                         n_typed;
        logic signed [SAMPLE_W-1:0] el;
        logic signed [SAMPLE_W-1:0] er;
    } stim_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [2*SAMPLE_W-1:0] s_tdata   = '0;   // in_left [15:0], in_right [31:16]
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [2*SAMPLE_W-1:0] m_tdata;          // out_left [15:0], out_right [31:16]
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [STEP_W-1:0]     cfg_data  = '0;

    // resampler state as the predictor sees it
    logic [STEP_W-1:0] step_reg = STEP_RESET;
    frame_t            hist [3];
    frame_t            window [4];
    int                seen;
    int unsigned       pos;

    sample_out_t due_out[$];   // expected output frames, oldest first
    sample_out_t fresh[$];     // output frames of the input frame just taken

    stim_row_t directed [N_DIRECTED];

    bit calm         = 1'b0;
    bit hold_pending = 1'b0;
    int mismatches   = 0;
    int frames_sent  = 0;
    int results_seen = 0;
    int steps_written = 0;
    int cycles       = 0;

    cubic_hermite_stereo_resampler #(
        .PHASE_FRAC_BITS(FRAC)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #10 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // catmull-rom point, worked as (2*value + 1) scaled by 2^(3F), then round and clip
    function automatic logic signed [SAMPLE_W-1:0] catmull_point(input int p0, input int p1,
                                                                 input int p2, input int p3,
                                                                 input int unsigned t);
        logic signed [127:0] w0, w1, w2, w3, tt, d1, d3, a, b, c, acc, lim, mag;
        w0 = p0;
        w1 = p1;
        w2 = p2;
        w3 = p3;
        tt = t;
        d1 = 128'sd1 <<< FRAC;
        d3 = d1 * d1 * d1;
        a = w2 - w0;
        b = 2 * w0 - 5 * w1 + 4 * w2 - w3;
        c = 3 * w1 - 3 * w2 + w3 - w0;
        acc = ((c * tt + b * d1) * tt + a * d1 * d1) * tt + 2 * w1 * d3 + d3;
        lim = 65535 * d3;
        if (acc < -lim) return OUT_MIN;
        if (acc > lim) return OUT_MAX;
        // truncation toward zero of value + 0.5
        mag = (acc < 0) ? -acc : acc;
        mag = mag >>> (3 * FRAC + 1);
        return (acc < 0) ? -mag[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 7))
            0: return OUT_MAX;
            1: return OUT_MIN;
            2: return raw[5:0] - 32;
            default: return raw[SAMPLE_W-1:0];
        endcase
    endfunction

    task automatic clear_chunk();
        for (int i = 0; i < 3; i++) begin
            hist[i] = '{16'sd0, 16'sd0};
        end
        pos  = 0;
        seen = 0;
    endtask

    // outputs of window slot j, taps clamped into [lo, 3]
    task automatic emit_slot(input int lo, input int j, input int unsigned stride);
        int          tap [4];
        int          v;
        int unsigned frac;
        sample_out_t o;
        for (int k = 0; k < 4; k++) begin
            v = j - 1 + k;
            tap[k] = (v < lo) ? lo : ((v > 3) ? 3 : v);
        end
        while ((pos >> FRAC) == 0 && fresh.size() < MAX_PER_FRAME) begin
            frac = pos & (ONE_FRAME - 1);
            o.l = catmull_point(window[tap[0]].l, window[tap[1]].l,
                                window[tap[2]].l, window[tap[3]].l, frac);
            o.r = catmull_point(window[tap[0]].r, window[tap[1]].r,
                                window[tap[2]].r, window[tap[3]].r, frac);
            o.last = 1'b0;
            fresh.push_back(o);
            pos += stride;
        end
        pos = (pos >= ONE_FRAME) ? pos - ONE_FRAME : 0;
    endtask

    // advance the predicted resampler by one input frame
    task automatic take_frame(input frame_t fr, input logic ends);
        int unsigned stride;
        int          lo;
        stride = (step_reg < QUARTER) ? QUARTER : step_reg;
        lo = 3 - seen;
        window[0] = hist[0];
        window[1] = hist[1];
        window[2] = hist[2];
        window[3] = fr;
        fresh.delete();
        if (ends) begin
            // flush the pending slots with the right-hand clamp
            for (int j = 1; j <= 3; j++) begin
                if (j >= lo) emit_slot(lo, j, stride);
            end
            clear_chunk();
        end else begin
            if (lo <= 1) emit_slot(lo, 1, stride);
            hist[0] = window[1];
            hist[1] = window[2];
            hist[2] = window[3];
            if (seen < 3) seen++;
        end
        if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    endtask

    // one input transfer, with an optional idle burst before it
    task automatic send_frame(input frame_t fr, input logic ends, input bit predicted,
                              input int idle_odds);
        int gap;
        if (idle_odds > 0 && $urandom_range(0, idle_odds - 1) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {fr.r, fr.l};
        s_tlast  <= ends;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        take_frame(fr, ends);
        frames_sent++;
        if (predicted) begin
            foreach (fresh[i]) due_out.push_back(fresh[i]);
        end
    endtask

    // stop sending, wait for every expected output, then let the block go quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (due_out.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        step_reg = value;
        steps_written++;
    endtask

    // output sink: random stalls, one long hold-off, clear stretches
    initial begin : result_sink
        int g;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                g = $urandom_range(1, 11);
                m_tready <= 1'b0;
                repeat (g - 1) @(posedge aclk);
            end else begin
                g = ($urandom_range(0, 39) == 0) ? $urandom_range(20, 60) : 1;
                m_tready <= 1'b1;
                repeat (g - 1) @(posedge aclk);
            end
        end
    end

    // output check, sampled mid-cycle so the transfer at the next edge is seen settled
    always @(negedge aclk) begin
        sample_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_out.size() == 0) begin
                $error("output transfer with nothing expected: tdata %h tlast %b",
                       m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = due_out.pop_front();
                results_seen++;
                if ($signed(m_tdata[15:0]) !== want.l) begin
                    $error("out_left: expected %0d, got %0d", want.l,
                           $signed(m_tdata[15:0]));
                    mismatches++;
                end
                if ($signed(m_tdata[31:16]) !== want.r) begin
                    $error("out_right: expected %0d, got %0d", want.r,
                           $signed(m_tdata[31:16]));
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $error("run_last: expected %0d, got %0d", want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        frame_t            fr;
        int                left_items;
        int                len;
        int                idle_odds;
        logic [STEP_W-1:0] next_step;

        // at the reset step a one-frame chunk gives two equal outputs;
        // negative levels round up by one since value + 0.5 is cut toward zero
        directed = '{
            '{16'sd0,      16'sd0,      1'b1, 2,       16'sd0,      16'sd0},
            '{OUT_MAX,     OUT_MIN,     1'b1, 2,       OUT_MAX,     -16'sd32767},
            '{OUT_MIN,     OUT_MAX,     1'b1, 2,       -16'sd32767, OUT_MAX},
            '{-16'sd1,     16'sd1,      1'b1, 2,       16'sd0,      16'sd1},
            // two-frame chunk
            '{16'sd100,    -16'sd100,   1'b0, PREDICT, 16'sd0,      16'sd0},
            '{-16'sd2000,  16'sd3000,   1'b1, PREDICT, 16'sd0,      16'sd0},
            // full-scale swings, overshoot clips both ways
            '{OUT_MIN,     OUT_MAX,     1'b0, PREDICT, 16'sd0,      16'sd0},
            '{OUT_MAX,     OUT_MIN,     1'b0, PREDICT, 16'sd0,      16'sd0},
            '{OUT_MAX,     OUT_MIN,     1'b0, PREDICT, 16'sd0,      16'sd0},
            '{OUT_MIN,     OUT_MAX,     1'b0, PREDICT, 16'sd0,      16'sd0},
            '{OUT_MIN,     OUT_MAX,     1'b0, PREDICT, 16'sd0,      16'sd0},
            '{OUT_MAX,     OUT_MIN,     1'b0, PREDICT, 16'sd0,      16'sd0},
            '{OUT_MAX,     OUT_MIN,     1'b1, PREDICT, 16'sd0,      16'sd0},
            // bit patterns in a longer chunk
            '{16'sd1,      -16'sd1,     1'b0, PREDICT, 16'sd0,      16'sd0},
            '{16'sd255,    -16'sd256,   1'b0, PREDICT, 16'sd0,      16'sd0},
            '{-16'sd21846, 16'sd21845,  1'b0, PREDICT, 16'sd0,      16'sd0},
            '{16'sd21845,  -16'sd21846, 1'b0, PREDICT, 16'sd0,      16'sd0},
            '{16'sd4096,   -16'sd4096,  1'b0, PREDICT, 16'sd0,      16'sd0},
            '{16'sd0,      16'sd0,      1'b0, PREDICT, 16'sd0,      16'sd0},
            '{16'sd7,      -16'sd7,     1'b1, PREDICT, 16'sd0,      16'sd0},
            // three-frame chunk
            '{16'sd500,    16'sd600,    1'b0, PREDICT, 16'sd0,      16'sd0},
            '{-16'sd700,   16'sd800,    1'b0, PREDICT, 16'sd0,      16'sd0},
            '{16'sd900,    -16'sd1000,  1'b1, PREDICT, 16'sd0,      16'sd0}
        };

        clear_chunk();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames at the reset step
        for (int k = 0; k < N_DIRECTED; k++) begin
            fr.l = directed[k].l;
            fr.r = directed[k].r;
            send_frame(fr, directed[k].ends, directed[k].n_typed == PREDICT, 0);
            for (int i = 0; i < directed[k].n_typed; i++) begin
                due_out.push_back('{directed[k].el, directed[k].er,
                                    i == directed[k].n_typed - 1});
            end
        end

        // random chunks, one step setting per phase
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: next_step = QUARTER;
                1: next_step = STEP_MAX;
                2: next_step = '0;
                3: next_step = ONE_FRAME;
                4: next_step = QUARTER - 1;
                default: next_step = $urandom_range(QUARTER, STEP_MAX);
            endcase
            drain();
            write_step(next_step);
            calm = (ph == N_PHASES - 1);
            // a phase at the densest step: hold the output off while frames keep coming
            if (ph == 0) hold_pending = 1'b1;
            left_items = PHASE_ITEMS;
            while (left_items > 0) begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
                if (len > left_items) len = left_items;
                case ($urandom_range(0, 2))
                    0: idle_odds = 0;
                    1: idle_odds = 3;
                    default: idle_odds = 8;
                endcase
                if (calm) idle_odds = 0;
                for (int k = 0; k < len; k++) begin
                    fr.l = random_sample();
                    fr.r = random_sample();
                    send_frame(fr, k == len - 1, 1'b1, idle_odds);
                end
                left_items -= len;
            end
        end

        drain();
        $display("%0d input frames in chunks of 1 to 24, %0d output frames checked",
                 frames_sent, results_seen);
        $display("reset step plus %0d written steps, floor, clamp and maximum among them",
                 steps_written);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/chsr_pkg.sv
design/chsr_lane.sv
design/chsr_datapath.sv
design/chsr_ctrl.sv
design/cubic_hermite_stereo_resampler.sv
tb/tb_cubic_hermite_stereo_resampler.sv
